### rtl/brbo_pkg.sv
// Package for the byte ring buffer with overflow.
// Holds field widths, operation and status codes, and the result struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brbo_pkg;

  localparam int unsigned MAX_DEPTH_DEF = 1024;

  localparam int unsigned CAP_W    = 11;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE    = 3'd0,
    MODE_OVERFLOW = 3'd1,
    MODE_POP      = 3'd2,
    MODE_PEEK     = 3'd3,
    MODE_CLEAR    = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // Result fields other than the read byte, which comes from the store.
  typedef struct packed {
    status_e          status;
    logic             dropped;
    logic             data_sel;
    logic [CAP_W-1:0] fill_level;
  } res_t;

endpackage

`default_nettype wire

### rtl/brbo_mem.sv
// Byte store of the ring buffer: one write port and one registered read port.
// Uses no package.
`timescale 1ns / 1ps
`default_nettype none

module brbo_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/brbo_ctrl.sv
// Pointer and fill-count control of the ring buffer.
// Computes the next state, the store access and the result of one beat.
// Depends on brbo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brbo_ctrl
  import brbo_pkg::*;
#(
  parameter int unsigned MaxDepth = MAX_DEPTH_DEF,
  parameter int unsigned AW       = 10,
  parameter int unsigned CW       = 11
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CAP_W-1:0]    cfg_wdata_i,
  input  wire logic                item_en_i,
  input  wire logic [MODE_W-1:0]   mode_i,
  input  wire logic [BYTE_W-1:0]   data_in_i,
  input  wire logic [OFFSET_W-1:0] offset_i,
  output res_t                     result_o,
  output logic                     mem_we_o,
  output logic [AW-1:0]            mem_waddr_o,
  output logic [BYTE_W-1:0]        mem_wdata_o,
  output logic                     mem_re_o,
  output logic [AW-1:0]            mem_raddr_o
);

  localparam int unsigned SW = ((AW > OFFSET_W) ? AW : OFFSET_W) + 1;
  localparam int unsigned EW = (CW > CAP_W) ? CW : CAP_W;

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cap_q, cap_d;

  logic          full;
  logic          empty;
  logic          peek_oor;
  logic [SW-1:0] peek_sum;
  logic [EW-1:0] wcap;
  logic          we;
  logic          re;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                            input logic [CW-1:0] cap);
    logic [CW-1:0] nxt;
    nxt = CW'(idx) + CW'(1);
    if (nxt >= cap) begin
      return '0;
    end
    return nxt[AW-1:0];
  endfunction

  // Clamp the written capacity into 1..MaxDepth once, at write time.
  always_comb begin
    wcap = EW'(cfg_wdata_i);
    if (wcap == '0) begin
      cap_d = CW'(1);
    end else if (wcap > EW'(MaxDepth)) begin
      cap_d = CW'(MaxDepth);
    end else begin
      cap_d = CW'(wcap);
    end
  end

  assign full     = (count_q >= cap_q);
  assign empty    = (count_q == '0);
  assign peek_oor = (SW'(offset_i) >= SW'(count_q));

  // The offset is below the fill, so one wrap correction is enough.
  always_comb begin
    peek_sum = SW'(head_q) + SW'(offset_i);
    if (peek_sum >= SW'(cap_q)) begin
      peek_sum = peek_sum - SW'(cap_q);
    end
  end

  always_comb begin
    head_d              = head_q;
    tail_d              = tail_q;
    count_d             = count_q;
    we                  = 1'b0;
    re                  = 1'b0;
    mem_raddr_o         = head_q;
    result_o.status     = STAT_DONE;
    result_o.dropped    = 1'b0;
    result_o.data_sel   = 1'b0;
    unique case (mode_e'(mode_i))
      MODE_WRITE: begin
        if (full) begin
          result_o.status = STAT_FULL;
        end else begin
          we      = 1'b1;
          tail_d  = advance(tail_q, cap_q);
          count_d = count_q + CW'(1);
        end
      end
      MODE_OVERFLOW: begin
        we     = 1'b1;
        tail_d = advance(tail_q, cap_q);
        if (full) begin
          head_d           = advance(head_q, cap_q);
          result_o.dropped = 1'b1;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      MODE_POP: begin
        if (empty) begin
          result_o.status = STAT_EMPTY;
        end else begin
          re                = 1'b1;
          result_o.data_sel = 1'b1;
          head_d            = advance(head_q, cap_q);
          count_d           = count_q - CW'(1);
        end
      end
      MODE_PEEK: begin
        mem_raddr_o = peek_sum[AW-1:0];
        if (peek_oor) begin
          result_o.status = STAT_EMPTY;
        end else begin
          re                = 1'b1;
          result_o.data_sel = 1'b1;
        end
      end
      MODE_CLEAR: begin
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
    result_o.fill_level = CAP_W'(count_d);
  end

  assign mem_we_o    = item_en_i & we;
  assign mem_re_o    = item_en_i & re;
  assign mem_waddr_o = tail_q;
  assign mem_wdata_o = data_in_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      cap_q   <= CW'(MaxDepth);
    end else if (cfg_we_i) begin
      // A new capacity starts from an empty buffer.
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      cap_q   <= cap_d;
    end else if (item_en_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

### rtl/byte_ring_buffer_with_overflow_core.sv
// A result beat appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; an input beat is taken whenever the result
// register is empty or its beat leaves in the same cycle.
// Reset clears the pointers and fill count and sets capacity to MaxDepth.
// The byte store is not cleared; only bytes written since emptying are read.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_buffer_with_overflow_core
  import brbo_pkg::*;
#(
  parameter int unsigned MaxDepth = MAX_DEPTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CAP_W-1:0]    cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [MODE_W-1:0]   mode_i,
  input  wire logic [BYTE_W-1:0]   data_in_i,
  input  wire logic [OFFSET_W-1:0] offset_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [BYTE_W-1:0]        data_out_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     dropped_oldest_o,
  output logic [CAP_W-1:0]         fill_level_o
);

  localparam int unsigned AW = $clog2(MaxDepth);
  localparam int unsigned CW = AW + 1;

  logic              in_accept;
  logic              out_valid_q;
  res_t              res_d, res_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  brbo_ctrl #(
    .MaxDepth (MaxDepth),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_en_i   (in_accept),
    .mode_i      (mode_i),
    .data_in_i   (data_in_i),
    .offset_i    (offset_i),
    .result_o    (res_d),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr)
  );

  // The store's read register is loaded in step with the result register.
  brbo_mem #(
    .Depth (MaxDepth),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_out_o       = res_q.data_sel ? mem_rdata : '0;
  assign status_o         = res_q.status;
  assign dropped_oldest_o = res_q.dropped;
  assign fill_level_o     = res_q.fill_level;

`ifndef NO_ASSERTIONS
  a_accept_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted beat did not produce a result beat");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with an empty result register");

  a_drop_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.dropped) |-> (res_q.status == STAT_DONE))
    else $error("dropped oldest byte on a failed operation");

  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status != STAT_DONE) |-> (data_out_o == '0))
    else $error("failed operation returned a data byte");
`endif

endmodule

`default_nettype wire
